// ----- src/csu_pkg.sv -----
// Shared types, constants and decode helpers of the C string literal unescaper.
// Used by csu_front, csu_queue, csu_back and c_string_literal_unescaper.
// Depends on nothing.
`default_nettype none

package csu_pkg;

  // Decoder phase codes
  localparam logic [2:0] PH_SEEK = 3'd0;
  localparam logic [2:0] PH_BODY = 3'd1;
  localparam logic [2:0] PH_ESC  = 3'd2;
  localparam logic [2:0] PH_HEX1 = 3'd3;
  localparam logic [2:0] PH_HEX2 = 3'd4;
  localparam logic [2:0] PH_OCT2 = 3'd5;
  localparam logic [2:0] PH_OCT3 = 3'd6;
  localparam logic [2:0] PH_DONE = 3'd7;

  // Warning codes
  localparam logic [2:0] W_NONE      = 3'd0;
  localparam logic [2:0] W_NO_OPEN   = 3'd1;
  localparam logic [2:0] W_NO_CLOSE  = 3'd2;
  localparam logic [2:0] W_NUL       = 3'd3;
  localparam logic [2:0] W_EMPTY_HEX = 3'd4;
  localparam logic [2:0] W_BIG_OCT   = 3'd5;
  localparam logic [2:0] W_UNKNOWN   = 3'd6;
  localparam logic [2:0] W_LENGTH    = 3'd7;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_N  = 8'h6E;
  localparam logic [7:0] CH_LC_R  = 8'h72;
  localparam logic [7:0] CH_LC_T  = 8'h74;
  localparam logic [7:0] CH_LC_V  = 8'h76;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_CASE  = 8'h20;

  // Reset value of the size register and default queue depth
  localparam logic [7:0] MAX_CHARS_RST = 8'd64;
  localparam int unsigned QDEPTH_DEF = 4;

  // One result item
  typedef struct packed {
    logic       has_char;
    logic [7:0] out_char;
    logic       eos;
    logic [2:0] warn;
  } res_t;

  // One queue entry: the results of one input item (one or two)
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic       emit;
    res_t       res;
    logic [2:0] ph;
    logic       inc;
  } body_t;

  typedef struct packed {
    res_t       res;
    logic [2:0] ph;
    logic       inc;
  } code_t;

  function automatic res_t mk_res(input logic has, input logic [7:0] ch,
                                  input logic eos, input logic [2:0] warn);
    res_t r;
    r.has_char = has;
    r.out_char = ch;
    r.eos      = eos;
    r.warn     = warn;
    return r;
  endfunction

  function automatic hex_t hexval(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c inside {[8'h30:8'h39]}) h.val = c[3:0];
    else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) h.val = c[3:0] + 4'd9;
    else h.ok = 1'b0;
    return h;
  endfunction

  // Ordinary byte inside the literal
  function automatic body_t body_f(input logic [7:0] c, input logic [7:0] oc,
                                   input logic [7:0] lim);
    body_t b;
    b.emit = 1'b1;
    b.inc  = 1'b0;
    b.ph   = PH_DONE;
    b.res  = mk_res(1'b0, 8'd0, 1'b1, W_NONE);
    if (oc >= lim) begin
      b.res.warn = (c == CH_QUOTE) ? W_NONE : W_LENGTH;
    end else if (c == CH_NUL || c == CH_NL) begin
      b.res.warn = W_NO_CLOSE;
    end else if (c == CH_QUOTE) begin
      b.res.warn = W_NONE;
    end else if (c == CH_BSL) begin
      b.emit = 1'b0;
      b.ph   = PH_ESC;
    end else begin
      b.inc = 1'b1;
      b.ph  = PH_BODY;
      b.res = mk_res(1'b1, c, 1'b0, W_NONE);
    end
    return b;
  endfunction

  // Finished hex or octal code
  function automatic code_t code_f(input logic [8:0] v);
    code_t k;
    k.inc = 1'b1;
    k.ph  = PH_BODY;
    k.res = mk_res(1'b1, v[7:0], 1'b0, W_NONE);
    if (v[8]) begin
      k.inc = 1'b0;
      k.res = mk_res(1'b0, 8'd0, 1'b0, W_BIG_OCT);
    end else if (v == 9'd0) begin
      k.ph  = PH_DONE;
      k.res = mk_res(1'b1, 8'd0, 1'b1, W_NUL);
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- src/csu_front.sv -----
// Front part: takes input bytes, runs the escape decoder and builds queue entries.
// Holds the size register and the decoder state. Depends on csu_pkg.
`default_nettype none

module csu_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_valid_i,
  input  wire logic [7:0]      cfg_data_i,
  input  wire logic            in_valid_i,
  input  wire logic            begin_req_i,
  input  wire logic [7:0]      in_char_i,
  input  wire logic            q_full_i,
  output logic                 in_ready_o,
  output logic                 push_o,
  output csu_pkg::entry_t      push_data_o
);

  logic [7:0] max_q;
  logic [2:0] phase_q, phase_d;
  logic [7:0] oc_q, oc_d;
  logic [8:0] cv_q, cv_d;

  logic            acc;
  logic [7:0]      lim;
  logic [2:0]      ph;
  logic [7:0]      oc, oc1;
  logic [8:0]      cv;
  logic            e0, e1;
  csu_pkg::res_t   r0, r1;
  csu_pkg::hex_t   hx;
  csu_pkg::body_t  bd;
  csu_pkg::code_t  kd;
  logic [7:0]      esc_ch;
  logic [2:0]      esc_w;
  logic            esc_simple;
  logic            odig;

  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign lim        = (max_q == 8'd0) ? 8'd0 : max_q - 8'd1;

  // Size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= csu_pkg::MAX_CHARS_RST;
    end else if (cfg_valid_i) begin
      max_q <= cfg_data_i;
    end
  end

  // Decoder step
  always_comb begin
    ph      = begin_req_i ? csu_pkg::PH_SEEK : phase_q;
    oc      = begin_req_i ? 8'd0 : oc_q;
    cv      = begin_req_i ? 9'd0 : cv_q;
    phase_d = ph;
    oc_d    = oc;
    cv_d    = cv;
    oc1     = oc;
    e0      = 1'b0;
    e1      = 1'b0;
    r0      = '0;
    r1      = '0;
    hx      = csu_pkg::hexval(in_char_i);
    bd      = '0;
    kd      = '0;
    esc_ch  = in_char_i;
    esc_w   = csu_pkg::W_NONE;
    esc_simple = 1'b1;
    odig    = in_char_i inside {[8'h30:8'h37]};
    case (ph)
      csu_pkg::PH_SEEK: begin
        if (in_char_i == csu_pkg::CH_QUOTE) begin
          phase_d = csu_pkg::PH_BODY;
        end else if (in_char_i == csu_pkg::CH_NUL || in_char_i == csu_pkg::CH_NL) begin
          phase_d = csu_pkg::PH_DONE;
          e0      = 1'b1;
          r0      = csu_pkg::mk_res(1'b0, 8'd0, 1'b0, csu_pkg::W_NO_OPEN);
        end
      end
      csu_pkg::PH_BODY: begin
        bd      = csu_pkg::body_f(in_char_i, oc, lim);
        e0      = bd.emit;
        r0      = bd.res;
        phase_d = bd.ph;
        oc_d    = oc + {7'd0, bd.inc};
      end
      csu_pkg::PH_ESC: begin
        if (in_char_i == csu_pkg::CH_NUL || in_char_i == csu_pkg::CH_NL) begin
          phase_d = csu_pkg::PH_DONE;
          e0      = 1'b1;
          r0      = csu_pkg::mk_res(1'b0, 8'd0, 1'b1, csu_pkg::W_NO_CLOSE);
        end else begin
          case (in_char_i | csu_pkg::CH_CASE)
            csu_pkg::CH_LC_A: esc_ch = 8'd7;
            csu_pkg::CH_LC_B: esc_ch = 8'd8;
            csu_pkg::CH_LC_F: esc_ch = 8'd12;
            csu_pkg::CH_LC_N: esc_ch = 8'd10;
            csu_pkg::CH_LC_R: esc_ch = 8'd13;
            csu_pkg::CH_LC_T: esc_ch = 8'd9;
            csu_pkg::CH_LC_V: esc_ch = 8'd11;
            csu_pkg::CH_LC_X: begin
              esc_simple = 1'b0;
              phase_d    = csu_pkg::PH_HEX1;
              cv_d       = 9'd0;
            end
            default: begin
              if (odig) begin
                esc_simple = 1'b0;
                cv_d       = {6'd0, in_char_i[2:0]};
                phase_d    = csu_pkg::PH_OCT2;
              end else if (!(in_char_i inside {csu_pkg::CH_BSL, csu_pkg::CH_QMARK,
                                               csu_pkg::CH_APOS, csu_pkg::CH_QUOTE})) begin
                esc_w = csu_pkg::W_UNKNOWN;
              end
            end
          endcase
          if (esc_simple) begin
            e0      = 1'b1;
            r0      = csu_pkg::mk_res(1'b1, esc_ch, 1'b0, esc_w);
            oc_d    = oc + 8'd1;
            phase_d = csu_pkg::PH_BODY;
          end
        end
      end
      csu_pkg::PH_HEX1: begin
        if (!hx.ok) begin
          phase_d = csu_pkg::PH_DONE;
          e0      = 1'b1;
          r0      = csu_pkg::mk_res(1'b0, 8'd0, 1'b1, csu_pkg::W_EMPTY_HEX);
        end else begin
          cv_d    = {5'd0, hx.val};
          phase_d = csu_pkg::PH_HEX2;
        end
      end
      csu_pkg::PH_HEX2, csu_pkg::PH_OCT2, csu_pkg::PH_OCT3: begin
        if (ph == csu_pkg::PH_HEX2 && hx.ok) begin
          kd      = csu_pkg::code_f({1'b0, cv[3:0], hx.val});
          e0      = 1'b1;
          r0      = kd.res;
          phase_d = kd.ph;
          oc_d    = oc + {7'd0, kd.inc};
          cv_d    = 9'd0;
        end else if (ph == csu_pkg::PH_OCT2 && odig) begin
          cv_d    = {cv[5:0], in_char_i[2:0]};
          phase_d = csu_pkg::PH_OCT3;
        end else if (ph == csu_pkg::PH_OCT3 && odig) begin
          kd      = csu_pkg::code_f({cv[5:0], in_char_i[2:0]});
          e0      = 1'b1;
          r0      = kd.res;
          phase_d = kd.ph;
          oc_d    = oc + {7'd0, kd.inc};
          cv_d    = 9'd0;
        end else begin
          // code ended early: emit it, then, unless it was NUL, decode this byte as ordinary text
          kd      = csu_pkg::code_f(cv);
          e0      = 1'b1;
          r0      = kd.res;
          cv_d    = 9'd0;
          oc1     = oc + {7'd0, kd.inc};
          oc_d    = oc1;
          phase_d = kd.ph;
          if (kd.ph == csu_pkg::PH_BODY) begin
            bd      = csu_pkg::body_f(in_char_i, oc1, lim);
            e1      = bd.emit;
            r1      = bd.res;
            phase_d = bd.ph;
            oc_d    = oc1 + {7'd0, bd.inc};
          end
        end
      end
      default: ;
    endcase
  end

  // Decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= csu_pkg::PH_SEEK;
      oc_q    <= 8'd0;
      cv_q    <= 9'd0;
    end else if (acc) begin
      phase_q <= phase_d;
      oc_q    <= oc_d;
      cv_q    <= cv_d;
    end
  end

  assign push_o          = acc && e0;
  assign push_data_o.two = e1;
  assign push_data_o.r0  = r0;
  assign push_data_o.r1  = r1;

endmodule

`default_nettype wire

// ----- src/csu_queue.sv -----
// Short queue of decoded entries between the front and back parts.
// Flip-flop storage, one push and one pop per cycle. Depends on csu_pkg.
`default_nettype none

module csu_queue #(
  parameter int unsigned Depth = csu_pkg::QDEPTH_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire csu_pkg::entry_t push_data_i,
  input  wire logic            pop_i,
  output csu_pkg::entry_t      head_o,
  output logic                 empty_o,
  output logic                 full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  csu_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntFull);
  assign head_o  = mem_q[rd_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Occupancy count
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + CntW'(1);
    else if (!push_i && pop_i) cnt_d = cnt_q - CntW'(1);
  end

  // Pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_q <= (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
      if (pop_i)  rd_q <= (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("queue count out of range");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> !empty_o)
    else $error("queue lost a written entry");

endmodule

`default_nettype wire

// ----- src/csu_back.sv -----
// Back part: unpacks queue entries into single result items on the output stream.
// Holds the output register. Depends on csu_pkg.
`default_nettype none

module csu_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire csu_pkg::entry_t head_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [7:0]           out_char_o,
  output logic [4:0]           out_user_o,
  output logic                 out_last_o
);

  logic          vld_q;
  logic          sel_q, sel_d;
  csu_pkg::res_t res_q, res_d;
  logic          last_q, last_d;
  logic          load;

  assign load = (!vld_q || out_ready_i) && !empty_i;

  // Pick the next result of the head entry
  always_comb begin
    sel_d  = sel_q;
    pop_o  = 1'b0;
    res_d  = head_i.r0;
    last_d = 1'b1;
    if (load) begin
      if (head_i.two && !sel_q) begin
        last_d = 1'b0;
        sel_d  = 1'b1;
      end else begin
        res_d = sel_q ? head_i.r1 : head_i.r0;
        pop_o = 1'b1;
        sel_d = 1'b0;
      end
    end
  end

  // Control of the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
      if (load) vld_q <= 1'b1;
      else if (out_ready_i) vld_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= res_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_char_o  = res_q.out_char;
  assign out_user_o  = {res_q.warn, res_q.eos, res_q.has_char};
  assign out_last_o  = last_q;

  a_no_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !res_q.has_char) |-> (res_q.out_char == 8'd0))
    else $error("result without a byte carries nonzero data");

  a_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !pop_o) |=> (vld_q && !last_q))
    else $error("first of two results marked last");

  a_sel_only_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sel_q && !empty_i) |-> head_i.two)
    else $error("second result selected on a single-result entry");

endmodule

`default_nettype wire

// ----- src/c_string_literal_unescaper.sv -----
// Top level of the C string literal unescaper: front decoder, entry queue, output stage.
// Depends on csu_pkg, csu_front, csu_queue and csu_back.
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+----------------------------------------------
//  s_axis  | in  | s_axis_tvalid/tready       | tdata[7:0] in_char; tuser[0] begin_req
//  m_axis  | out | m_axis_tvalid/tready       | tdata[7:0] out_char; tuser has_char, eos,
//          |     |                            | warning_code[2:0]; tlast last
//  cfg     | in  | cfg_valid_i/cfg_ready_o    | cfg_data_i[7:0] max_chars
//
// One input byte is taken every cycle while the queue has room; the decoder step is combinational.
// Results leave one per cycle from the output register while m_axis_tready is high, so a
// byte that yields two results holds the output for both in turn; the queue (QDepth entries)
// absorbs such bursts. An item's results pass through the entry queue and then the output
// register before they appear on m_axis.
// Reset clears the decoder state and sets max_chars to 64; no clearing pass is needed.
// A stall on the output fills the queue, then drops s_axis_tready.
`default_nettype none

module c_string_literal_unescaper #(
  parameter int unsigned QDepth = csu_pkg::QDEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_char
  input  wire logic [0:0] s_axis_tuser,   // [0] begin_req
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_char
  output logic [4:0]      m_axis_tuser,   // [0] has_char, [1] end_of_string, [4:2] warning_code
  output logic            m_axis_tlast
);

  logic            push, pop, q_empty, q_full;
  csu_pkg::entry_t push_data, head;

  assign cfg_ready_o = 1'b1;

  csu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .begin_req_i (s_axis_tuser[0]),
    .in_char_i   (s_axis_tdata),
    .q_full_i    (q_full),
    .in_ready_o  (s_axis_tready),
    .push_o      (push),
    .push_data_o (push_data)
  );

  csu_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  csu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire
